/* hdl/bms_pkg.sv */
// Shared types and constants of the bilinear mask sampler.
package bms_pkg;

	// Action codes of an input item
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH_MODE   = 2'd2;

	// Depth codes
	localparam logic DEPTH_1BIT = 1'b0;
	localparam logic DEPTH_8BIT = 1'b1;

	localparam int SIZE_W    = 9;   // width of a size register
	localparam int COORD_W   = 16;  // Q2.14 coordinate
	localparam int FRAC_W    = 14;
	localparam int SCALED_W  = 26;  // coordinate times size
	localparam int CFG_W     = 9;
	localparam int OUT_DEPTH = 4;   // result queue depth

	// Item passed from front to back, coordinates already scaled
	typedef struct packed {
		logic                       act;
		logic [7:0]                 col;
		logic [7:0]                 row;
		logic [7:0]                 val;
		logic signed [SCALED_W-1:0] su;
		logic signed [SCALED_W-1:0] sv;
	} item_t;

endpackage

/* hdl/bilinear_mask_sampler.sv */
// Top level of the bilinear mask sampler: configuration registers and front/back ends.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   action, pixel_col, pixel_row, pixel_value,
//                                            sample_u, sample_v
//  out      output     out_valid / out_ready sampled_value
//  cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; four pixel banks split by
// row and column parity give all four neighbors in a single read.
// A sample is registered into the front queue, then clamped and read from the banks,
// blended horizontally, and blended vertically into the result queue; a write goes
// through the front queue and reaches the pixel store when the back end pops it.
// Reset clears control state and sets size 1x1, 8-bit depth; pixel store is
// undefined until written. A stalled output holds the result queue; the
// front queue keeps accepting until it fills.
module bilinear_mask_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [1:0]                       cfg_index,
	input  logic [bms_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [7:0]                       pixel_col,
	input  logic [7:0]                       pixel_row,
	input  logic [7:0]                       pixel_value,
	input  logic signed [bms_pkg::COORD_W-1:0] sample_u,
	input  logic signed [bms_pkg::COORD_W-1:0] sample_v,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       sampled_value
);
	import bms_pkg::*;

	logic [SIZE_W-1:0] width_q, height_q, eff_w, eff_h;
	logic              depth_q;
	logic              q_valid, q_pop;
	item_t             q_item;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd1;
			height_q <= 9'd1;
			depth_q  <= DEPTH_8BIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_DEPTH_MODE:   depth_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective size: zero reads as one, saturate at store size
	always_comb begin
		eff_w = width_q;
		if (width_q == '0) eff_w = 9'd1;
		else if (32'(width_q) > MAX_WIDTH) eff_w = SIZE_W'(MAX_WIDTH);
		eff_h = height_q;
		if (height_q == '0) eff_h = 9'd1;
		else if (32'(height_q) > MAX_HEIGHT) eff_h = SIZE_W'(MAX_HEIGHT);
	end

	bms_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.pixel_col  (pixel_col),
		.pixel_row  (pixel_row),
		.pixel_value(pixel_value),
		.sample_u   (sample_u),
		.sample_v   (sample_v),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.depth_mode (depth_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	bms_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.eff_w        (eff_w),
		.eff_h        (eff_h),
		.depth_mode   (depth_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sampled_value(sampled_value)
	);
endmodule

/* hdl/bms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/bms_front.sv */
// Front end: accepts items, scales coordinates, queues work for the back end.
module bms_front #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [7:0]                       pixel_col,
	input  logic [7:0]                       pixel_row,
	input  logic [7:0]                       pixel_value,
	input  logic signed [bms_pkg::COORD_W-1:0] sample_u,
	input  logic signed [bms_pkg::COORD_W-1:0] sample_v,
	input  logic [bms_pkg::SIZE_W-1:0]       eff_w,
	input  logic [bms_pkg::SIZE_W-1:0]       eff_h,
	input  logic                             depth_mode,
	output logic                             q_valid,
	output bms_pkg::item_t                   q_item,
	input  logic                             q_pop
);
	import bms_pkg::*;

	item_t      queue_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	item_t      new_item;
	logic       accept, drop, push;

	// Classify and scale the incoming item
	always_comb begin
		drop = (action == ACT_WRITE) &&
			((32'(pixel_col) >= MAX_WIDTH) || (32'(pixel_row) >= MAX_HEIGHT));
		new_item.act = action;
		new_item.col = pixel_col;
		new_item.row = pixel_row;
		new_item.val = (depth_mode == DEPTH_1BIT) ? {7'd0, pixel_value[0]} : pixel_value;
		new_item.su  = SCALED_W'(sample_u) * $signed({1'b0, eff_w});
		new_item.sv  = SCALED_W'(sample_v) * $signed({1'b0, eff_h});
	end

	assign in_ready = (cnt_q != 2'd2);
	assign accept   = in_valid && in_ready;
	assign push     = accept && !drop;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = queue_q[rptr_q];

	// Store queued items
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= new_item;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

/* hdl/bms_back.sv */
// Back end: clamps, reads four pixel banks, interpolates, queues results.
module bms_back #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  bms_pkg::item_t             q_item,
	output logic                       q_pop,
	input  logic [bms_pkg::SIZE_W-1:0] eff_w,
	input  logic [bms_pkg::SIZE_W-1:0] eff_h,
	input  logic                       depth_mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 sampled_value
);
	import bms_pkg::*;

	localparam int CWH   = (MAX_WIDTH + 1) / 2;
	localparam int CHH   = (MAX_HEIGHT + 1) / 2;
	localparam int BDEP  = CWH * CHH;
	localparam int AW    = BDEP > 1 ? $clog2(BDEP) : 1;
	localparam int OPW   = $clog2(OUT_DEPTH);
	localparam int OCW   = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [SIZE_W-1:0] idx;
		logic [FRAC_W-1:0] frac;
	} axis_t;

	// Scaled coordinate to clamped index and fraction
	function automatic axis_t split_axis(input logic signed [SCALED_W-1:0] s,
			input logic [SIZE_W-1:0] size);
		logic signed [SCALED_W-FRAC_W-1:0] q;
		logic signed [SCALED_W-FRAC_W-1:0] lim;
		axis_t r;
		q      = s[SCALED_W-1:FRAC_W];
		lim    = $signed({3'b000, size - 9'd1});
		r.idx  = q[SIZE_W-1:0];
		r.frac = s[FRAC_W-1:0];
		if (q < 0) begin
			r.idx  = '0;
			r.frac = '0;
		end else if (q >= lim) begin
			r.idx  = lim[SIZE_W-1:0];
			r.frac = '0;
		end
		return r;
	endfunction

	// Half index of the even neighbor, wrapping past the store edge
	function automatic logic [31:0] even_half(input logic [SIZE_W-1:0] i, input int half);
		logic [31:0] e;
		e = 32'(i >> 1) + 32'(i[0]);
		if (e >= 32'(half)) e = '0;
		return e;
	endfunction

	function automatic logic [7:0] px(input logic [7:0] v, input logic dm);
		return (dm == DEPTH_8BIT) ? v : {8{v[0]}};
	endfunction

	axis_t            ax, ay;
	logic [31:0]      colh [2];
	logic [31:0]      rowh [2];
	logic [AW-1:0]    raddr [4];
	logic [7:0]       rdata [4];
	logic [AW-1:0]    waddr;
	logic [1:0]       wbank;
	logic             do_write, do_read;

	logic             s1_v, s2_v;
	logic             ix0_s1, iy0_s1;
	logic [FRAC_W-1:0] fx_s1, fy_s1, fy_s2;
	logic [21:0]      top_s2, bot_s2;
	logic [7:0]       c00, c01, c10, c11;
	logic [14:0]      wx0, wy0;
	logic [35:0]      vsum;

	logic [7:0]       ofifo_q [OUT_DEPTH];
	logic [OPW-1:0]   owptr_q, orptr_q;
	logic [OCW-1:0]   ocnt_q;
	logic             opop;

	// Issue: pop a write at once, and a sample when the result queue has room for everything in flight
	assign q_pop = q_valid && ((q_item.act == ACT_WRITE) ||
		((4'(ocnt_q) + 4'(s1_v) + 4'(s2_v)) < 4'(OUT_DEPTH)));
	assign do_write = q_pop && (q_item.act == ACT_WRITE);
	assign do_read  = q_pop && (q_item.act == ACT_SAMPLE);

	// Clamp and build the four bank addresses
	always_comb begin
		ax = split_axis(q_item.su, eff_w);
		ay = split_axis(q_item.sv, eff_h);
		colh[0] = even_half(ax.idx, CWH);
		colh[1] = 32'(ax.idx >> 1);
		rowh[0] = even_half(ay.idx, CHH);
		rowh[1] = 32'(ay.idx >> 1);
		for (int b = 0; b < 4; b++) begin
			raddr[b] = AW'(rowh[b / 2] * 32'(CWH) + colh[b % 2]);
		end
		wbank = {q_item.row[0], q_item.col[0]};
		waddr = AW'(32'(q_item.row >> 1) * 32'(CWH) + 32'(q_item.col >> 1));
	end

	// Pixel banks split by row and column parity
	for (genvar b = 0; b < 4; b++) begin : g_bank
		bms_ram #(.WIDTH(8), .DEPTH(BDEP)) u_ram (
			.clk  (clk),
			.we   (do_write && (wbank == 2'(b))),
			.waddr(waddr),
			.wdata(q_item.val),
			.re   (do_read),
			.raddr(raddr[b]),
			.rdata(rdata[b])
		);
	end

	// Stage 1 and stage 2 controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
		end else begin
			s1_v <= do_read;
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			ix0_s1 <= ax.idx[0];
			iy0_s1 <= ay.idx[0];
			fx_s1  <= ax.frac;
			fy_s1  <= ay.frac;
		end
	end

	// Route bank data to neighbors; a zero weight neighbor reads as zero
	always_comb begin
		c00 = px(rdata[{iy0_s1, ix0_s1}], depth_mode);
		c01 = px(rdata[{iy0_s1, ~ix0_s1}], depth_mode);
		c10 = px(rdata[{~iy0_s1, ix0_s1}], depth_mode);
		c11 = px(rdata[{~iy0_s1, ~ix0_s1}], depth_mode);
		if (fx_s1 == '0) begin
			c01 = '0;
			c11 = '0;
		end
		if (fy_s1 == '0) begin
			c10 = '0;
			c11 = '0;
		end
		wx0 = 15'd16384 - 15'(fx_s1);
	end

	// Horizontal blend
	always_ff @(posedge clk) begin
		if (s1_v) begin
			top_s2 <= 22'(c00) * 22'(wx0) + 22'(c01) * 22'(fx_s1);
			bot_s2 <= 22'(c10) * 22'(wx0) + 22'(c11) * 22'(fx_s1);
			fy_s2  <= fy_s1;
		end
	end

	// Vertical blend
	always_comb begin
		wy0  = 15'd16384 - 15'(fy_s2);
		vsum = 36'(top_s2) * 36'(wy0) + 36'(bot_s2) * 36'(fy_s2);
	end

	// Result queue
	assign opop          = out_valid && out_ready;
	assign out_valid     = (ocnt_q != '0);
	assign sampled_value = ofifo_q[orptr_q];

	always_ff @(posedge clk) begin
		if (s2_v) begin
			ofifo_q[owptr_q] <= vsum[35:28];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (s2_v) owptr_q <= owptr_q + OPW'(1);
			if (opop) orptr_q <= orptr_q + OPW'(1);
			ocnt_q <= ocnt_q + OCW'(s2_v) - OCW'(opop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v |-> (32'(ocnt_q) < OUT_DEPTH) || opop)
		else $error("result queue overflow");
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(4'(ocnt_q) + 4'(s1_v) + 4'(s2_v)) <= 4'(OUT_DEPTH))
		else $error("in-flight samples exceed result queue room");
	a_read_flows: assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> s1_v ##1 s2_v)
		else $error("sample lost in back pipeline");
`endif
endmodule

/* sim/bilinear_mask_sampler_tb.sv */
`timescale 1ns / 100ps
// Testbench of the bilinear mask sampler: directed table, then random pixel writes and samples.
module bilinear_mask_sampler_tb;
	import bms_pkg::*;

	localparam int MAX_W = 256;
	localparam int MAX_H = 256;
	localparam int ONE_Q14 = 16384;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 7;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        act;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  val;
		logic [15:0] u;
		logic [15:0] v;
	} mask_item_t;

	typedef struct {
		mask_item_t  it;
		bit          known;
		logic [7:0]  value;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_WRITE;
	logic [7:0] pixel_col = '0;
	logic [7:0] pixel_row = '0;
	logic [7:0] pixel_value = '0;
	logic signed [COORD_W-1:0] sample_u = '0;
	logic signed [COORD_W-1:0] sample_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] sampled_value;

	bilinear_mask_sampler DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pixel_col(pixel_col), .pixel_row(pixel_row),
		.pixel_value(pixel_value), .sample_u(sample_u), .sample_v(sample_v),
		.out_valid(out_valid), .out_ready(out_ready), .sampled_value(sampled_value)
	);

	// Shadow image and registers
	logic [7:0] shadow_pixels [0:MAX_W*MAX_H-1];
	int unsigned width_reg = 1;
	int unsigned height_reg = 1;
	logic depth_reg = DEPTH_8BIT;

	logic [7:0] expected_values [$];
	int fail_count = 0;
	int result_count = 0;
	int write_count = 0;
	int sample_count = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int rx_cycle = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	logic [7:0] want_value;

	// Image settings walked after the directed part
	int unsigned ph_width [PHASES] = '{4, 4, 256, 1, 0, 7, 2};
	int unsigned ph_height [PHASES] = '{3, 3, 1, 511, 0, 5, 2};
	logic ph_depth [PHASES] = '{DEPTH_8BIT, DEPTH_1BIT, DEPTH_1BIT, DEPTH_8BIT,
		DEPTH_8BIT, DEPTH_8BIT, DEPTH_1BIT};
	bit ph_fill [PHASES] = '{1, 0, 1, 1, 1, 1, 1};
	int ph_random [PHASES] = '{70, 60, 70, 70, 40, 220, 70};

	// Reset state is 1x1, 8-bit: single-pixel results read straight off the stored byte
	table_row_t dir_rows [14] = '{
		'{'{ACT_WRITE, 8'd0, 8'd0, 8'd255, 16'h0000, 16'h0000}, 1'b0, 8'd0},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000}, 1'b1, 8'd255},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h8000, 16'h8000}, 1'b1, 8'd255},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h7fff, 16'h7fff}, 1'b1, 8'd255},
		'{'{ACT_WRITE, 8'd255, 8'd255, 8'd170, 16'h0000, 16'h0000}, 1'b0, 8'd0},
		'{'{ACT_WRITE, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000}, 1'b0, 8'd0},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h4000, 16'hc000}, 1'b1, 8'd0},
		'{'{ACT_WRITE, 8'd0, 8'd0, 8'd128, 16'h0000, 16'h0000}, 1'b0, 8'd0},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h4000, 16'h0000}, 1'b1, 8'd128},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h04d2, 16'hfcf7}, 1'b0, 8'd0},
		'{'{ACT_WRITE, 8'd85, 8'd170, 8'd85, 16'hffff, 16'hffff}, 1'b0, 8'd0},
		'{'{ACT_WRITE, 8'd0, 8'd0, 8'd1, 16'h0000, 16'h0000}, 1'b0, 8'd0},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h3fff, 16'h0001}, 1'b1, 8'd1},
		'{'{ACT_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h2000, 16'h2000}, 1'b0, 8'd0}
	};

	function automatic int unsigned clamp_size(int unsigned r, int unsigned lim);
		if (r == 0) return 1;
		if (r > lim) return lim;
		return r;
	endfunction

	// Scale, floor-split and clamp one coordinate
	function automatic void split_axis(logic [15:0] c, int unsigned size,
			output int unsigned base, output int unsigned nxt, output int unsigned frac);
		longint s, q, f;
		s = longint'($signed(c)) * longint'(size);
		q = s >>> FRAC_W;
		f = s - q * ONE_Q14;
		if (q < 0) begin
			q = 0;
			f = 0;
		end else if (q >= longint'(size) - 1) begin
			q = longint'(size) - 1;
			f = 0;
		end
		base = int'(q);
		frac = int'(f);
		nxt = base + 1;
		if (nxt >= size) nxt = 0;
	endfunction

	function automatic longint unsigned pixel_weight(int unsigned col, int unsigned row);
		logic [7:0] b;
		b = shadow_pixels[row * MAX_W + col];
		if (depth_reg == DEPTH_1BIT) return b[0] ? 64'd255 : 64'd0;
		return 64'(b);
	endfunction

	function automatic logic [7:0] blend_sample(logic [15:0] u, logic [15:0] v);
		int unsigned ix, nx, fx, iy, ny, fy;
		longint unsigned top, bot, acc;
		split_axis(u, clamp_size(width_reg, MAX_W), ix, nx, fx);
		split_axis(v, clamp_size(height_reg, MAX_H), iy, ny, fy);
		top = pixel_weight(ix, iy) * (ONE_Q14 - fx) + pixel_weight(nx, iy) * fx;
		bot = pixel_weight(ix, ny) * (ONE_Q14 - fx) + pixel_weight(nx, ny) * fx;
		acc = top * (ONE_Q14 - fy) + bot * fy;
		return acc[35:28];
	endfunction

	// Offer one item, honoring burst gaps, and update the shadow once accepted
	task automatic send_item(mask_item_t it, bit known, logic [7:0] kval);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		action <= it.act;
		pixel_col <= it.col;
		pixel_row <= it.row;
		pixel_value <= it.val;
		sample_u <= it.u;
		sample_v <= it.v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		if (it.act == ACT_SAMPLE) begin
			expected_values.push_back(known ? kval : blend_sample(it.u, it.v));
			sample_count++;
		end else begin
			shadow_pixels[it.row * MAX_W + it.col] =
				(depth_reg == DEPTH_1BIT) ? {7'd0, it.val[0]} : it.val;
			write_count++;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: width_reg = 32'(data);
			REG_IMAGE_HEIGHT: height_reg = 32'(data);
			REG_DEPTH_MODE: depth_reg = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Drop valid, drain results, then let trailing writes settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		mask_item_t it;
		int k;
		k = $urandom_range(0, 99);
		it = '0;
		it.val = 8'($urandom);
		if (k < 22) begin
			it.act = ACT_WRITE;
			it.col = 8'($urandom_range(0, clamp_size(width_reg, MAX_W) - 1));
			it.row = 8'($urandom_range(0, clamp_size(height_reg, MAX_H) - 1));
		end else if (k < 27) begin
			it.act = ACT_WRITE;
			it.col = 8'($urandom);
			it.row = 8'($urandom);
		end else begin
			it.act = ACT_SAMPLE;
			it.u = (k % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, ONE_Q14));
			it.v = (k % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, ONE_Q14));
			it.col = 8'($urandom);
			it.row = 8'($urandom);
		end
		send_item(it, 1'b0, 8'd0);
	endtask

	always #5 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: shifting stall pattern, plus one long hold on request
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			case (rx_cycle[7:6])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count <= result_count + 1;
			if (expected_values.size() == 0) begin
				$error("sampled_value: expected none, actual %0d", sampled_value);
				fail_count <= fail_count + 1;
			end else begin
				want_value = expected_values.pop_front();
				if (sampled_value !== want_value) begin
					$error("sampled_value: expected %0d, actual %0d", want_value, sampled_value);
					fail_count <= fail_count + 1;
				end
			end
		end
	end

	initial begin
		mask_item_t it;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset setting
		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].value);
		wait_idle();
		write_reg(REG_UNUSED, 9'h1ff);

		// Walk the image settings; fill the used area before sampling where the phase asks for it
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_IMAGE_WIDTH, CFG_W'(ph_width[p]));
			write_reg(REG_IMAGE_HEIGHT, CFG_W'(ph_height[p]));
			write_reg(REG_DEPTH_MODE, CFG_W'(ph_depth[p]));
			if (ph_fill[p]) begin
				for (int r = 0; r < clamp_size(height_reg, MAX_H); r++) begin
					for (int c = 0; c < clamp_size(width_reg, MAX_W); c++) begin
						it = '0;
						it.act = ACT_WRITE;
						it.col = 8'(c);
						it.row = 8'(r);
						it.val = 8'($urandom);
						send_item(it, 1'b0, 8'd0);
					end
				end
			end
			if (p == 5) hold_req = 1'b1;
			repeat (ph_random[p]) random_item();
			wait_idle();
		end

		$display("covered %0d pixel writes and %0d samples over %0d image settings",
			write_count, sample_count, PHASES + 1);
		$display("results checked: %0d, mismatches: %0d", result_count, fail_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
